>>> hw/rtl/renc_pkg.sv
package renc_pkg;

    // Default parameter values
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int TIME_WIDTH_DEF  = 32;

    // Result queue sizing: one item causes at most MAX_EVENTS results
    localparam int MAX_EVENTS = 3;
    localparam int Q_DEPTH    = 4;

    // Input opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] REG_PRESS_BIAS   = 3'd0;
    localparam logic [2:0] REG_LONG_TIME    = 3'd1;
    localparam logic [2:0] REG_LOWER_LIMIT  = 3'd2;
    localparam logic [2:0] REG_UPPER_LIMIT  = 3'd3;
    localparam logic [2:0] REG_LOWER_ENABLE = 3'd4;
    localparam logic [2:0] REG_UPPER_ENABLE = 3'd5;
    localparam logic [2:0] REG_WRAP_ENABLE  = 3'd6;
    localparam logic [2:0] REG_BUTTON_EN    = 3'd7;

    // Register reset values
    localparam logic [15:0] PRESS_BIAS_RST = 16'd50;
    localparam logic [15:0] LONG_TIME_RST  = 16'd1000;

    // Event kinds
    localparam logic [2:0] EV_PRESS  = 3'd0;
    localparam logic [2:0] EV_RELEASE = 3'd1;
    localparam logic [2:0] EV_LONG   = 3'd2;
    localparam logic [2:0] EV_RIGHT  = 3'd3;
    localparam logic [2:0] EV_LEFT   = 3'd4;

    // Button phases
    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_PRESSED   = 2'd1;
    localparam logic [1:0] PH_CONFIRMED = 2'd2;

    // Pending directions
    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;

    // Quadrature codes {a, b}
    localparam logic [1:0] QC_BOTH_LOW = 2'b00;
    localparam logic [1:0] QC_B_HIGH   = 2'b01;
    localparam logic [1:0] QC_A_HIGH   = 2'b10;
    localparam logic [1:0] QC_REST     = 2'b11;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
        logic        down;
        logic [31:0] held;
        logic        rot;
        logic        last;
    } t_event;

endpackage

>>> hw/rtl/rotary_encoder_with_button_events.sv
// Rotary encoder decoder with push button events.
//
// Input channel (i_valid / o_ready): one beat is either a pin sample
// (i_opcode = 0: quadrature pins, button level, millisecond tick) or a
// counter load (i_opcode = 1: i_new_value). Output channel (o_valid /
// i_ready): one beat per event, o_last set on the final event of a sample.
// A sample causes zero to three events (long press, release or press,
// rotate), all worked out in the cycle the sample is accepted and written
// to a four-entry result queue, from which the events leave in order.
// A new beat is accepted every cycle as long as the queue, after this
// cycle's pop, holds at most one entry, so a sample that yields at most one
// event sustains one beat per cycle; a burst of three events leaves as three
// output beats. When the receiver stalls the queue fills and o_ready drops
// until room for three events is back.
// Configuration is a plain write port (i_cfg_we, i_cfg_addr, i_cfg_data),
// taken at any clock edge with i_cfg_we high.
// Synchronous reset (i_rst_n low) empties the queue, restores the register
// defaults and returns the decoder to its rest state (code 3, button idle).
module rotary_encoder_with_button_events
    import renc_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [31:0]        i_cfg_data,
    // input channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_opcode,
    input  logic               i_quad_a,
    input  logic               i_quad_b,
    input  logic               i_button_level,
    input  logic               i_ms_tick,
    input  logic signed [31:0] i_new_value,
    // output channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_event_kind,
    output logic signed [31:0] o_value,
    output logic               o_button_down,
    output logic [31:0]        o_held_time,
    output logic               o_rotated,
    output logic               o_last
);

    localparam int CW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
    localparam int HW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
    localparam int PW = $clog2(Q_DEPTH);
    localparam int NW = $clog2(Q_DEPTH + 1);

    // configuration registers
    logic [15:0]        r_press_bias;
    logic [15:0]        r_long_time;
    logic signed [31:0] r_lower_limit;
    logic signed [31:0] r_upper_limit;
    logic               r_lower_en;
    logic               r_upper_en;
    logic               r_wrap_en;
    logic               r_button_en;

    // decoder state
    logic [1:0]             r_last_code, n_last_code;
    logic [1:0]             r_dir, n_dir;
    logic [1:0]             r_phase, n_phase;
    logic [TIME_WIDTH-1:0]  r_elapsed, n_elapsed;
    logic [VALUE_WIDTH-1:0] r_counter, n_counter;
    logic                   r_pressed, n_pressed;
    logic                   r_rotated, n_rotated;

    // result queue
    t_event        r_queue [Q_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [NW-1:0] r_count;

    logic          w_in_acc;
    logic          w_pop;
    logic [1:0]    w_nev;
    t_event        w_wr [MAX_EVENTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_bias  <= PRESS_BIAS_RST;
            r_long_time   <= LONG_TIME_RST;
            r_lower_limit <= '0;
            r_upper_limit <= '0;
            r_lower_en    <= 1'b0;
            r_upper_en    <= 1'b0;
            r_wrap_en     <= 1'b0;
            r_button_en   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_PRESS_BIAS:   r_press_bias  <= i_cfg_data[15:0];
                REG_LONG_TIME:    r_long_time   <= i_cfg_data[15:0];
                REG_LOWER_LIMIT:  r_lower_limit <= i_cfg_data;
                REG_UPPER_LIMIT:  r_upper_limit <= i_cfg_data;
                REG_LOWER_ENABLE: r_lower_en    <= i_cfg_data[0];
                REG_UPPER_ENABLE: r_upper_en    <= i_cfg_data[0];
                REG_WRAP_ENABLE:  r_wrap_en     <= i_cfg_data[0];
                REG_BUTTON_EN:    r_button_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // One pass over a beat: counter load, or state update and up to three events
    always_comb begin
        logic [1:0]             code;
        logic                   level;
        logic [TIME_WIDTH-1:0]  el;
        logic [HW-1:0]          diff;
        logic [HW-1:0]          el_ext;
        logic [31:0]            held_rel;
        logic                   rel_rot;
        logic                   ev_long, ev_rel, ev_press, ev_rot;
        logic [2:0]             rot_kind;
        logic                   rot_down;
        logic [31:0]            rot_held;
        logic [VALUE_WIDTH-1:0] v;
        logic signed [CW-1:0]   sv, lo, hi, load_ext;
        logic [CW-1:0]          cnt_ext, v_ext;
        t_event                 ev [MAX_EVENTS];
        logic [MAX_EVENTS-1:0]  ev_ok;
        logic [1:0]             idx;

        code  = {i_quad_a, i_quad_b};
        level = i_button_level;

        n_last_code = r_last_code;
        n_dir       = r_dir;
        n_phase     = r_phase;
        n_elapsed   = r_elapsed;
        n_counter   = r_counter;
        n_pressed   = r_pressed;
        n_rotated   = r_rotated;

        ev_long  = 1'b0;
        ev_rel   = 1'b0;
        ev_press = 1'b0;
        ev_rot   = 1'b0;
        rot_kind = EV_RIGHT;
        rot_down = 1'b0;
        rot_held = '0;
        rel_rot  = 1'b0;
        held_rel = '0;
        diff     = '0;
        el_ext   = '0;
        el       = r_elapsed;
        v        = r_counter;
        lo       = CW'(r_lower_limit);
        hi       = CW'(r_upper_limit);
        sv       = '0;
        load_ext = CW'(i_new_value);

        if (i_opcode == OP_LOAD) begin
            n_counter = load_ext[VALUE_WIDTH-1:0];
        end else begin
            // saturate the press timer
            if (i_ms_tick && (r_elapsed != '1)) el = r_elapsed + 1'b1;

            if (!r_button_en) begin
                n_phase = PH_IDLE;
            end else begin
                if (!level && (n_phase == PH_IDLE)) begin
                    el        = '0;
                    n_phase   = PH_PRESSED;
                    n_pressed = 1'b0;
                end
                diff     = HW'(el) - HW'(r_press_bias);
                held_rel = diff[31:0];
                if (level && (n_phase == PH_CONFIRMED)) begin
                    ev_rel    = 1'b1;
                    ev_long   = HW'(el) > HW'(r_long_time);
                    rel_rot   = n_rotated;
                    n_rotated = 1'b0;
                    n_pressed = 1'b0;
                end
                if (level) n_phase = PH_IDLE;
                if ((HW'(el) >= HW'(r_press_bias)) && !level && (n_phase == PH_PRESSED)) begin
                    n_phase   = PH_CONFIRMED;
                    ev_press  = 1'b1;
                    n_rotated = 1'b0;
                end
            end

            // half step while held confirms the press at once
            if (((code == QC_A_HIGH) || (code == QC_B_HIGH)) && (n_phase != PH_IDLE)) begin
                n_pressed = 1'b1;
                if (r_button_en && !level && (n_phase == PH_PRESSED)) begin
                    n_phase   = PH_CONFIRMED;
                    ev_press  = 1'b1;
                    n_rotated = 1'b0;
                end
            end

            if ((code != r_last_code) && (code != QC_BOTH_LOW)) begin
                if (code == QC_REST) begin
                    if ((r_dir == DIR_RIGHT) || (r_dir == DIR_LEFT)) begin
                        v  = (r_dir == DIR_RIGHT) ? r_counter + 1'b1 : r_counter - 1'b1;
                        sv = CW'(signed'(v));
                        if (r_lower_en && (sv < lo)) v = r_wrap_en ? hi[VALUE_WIDTH-1:0]
                                                                  : lo[VALUE_WIDTH-1:0];
                        sv = CW'(signed'(v));
                        if (r_upper_en && (sv > hi)) v = r_wrap_en ? lo[VALUE_WIDTH-1:0]
                                                                  : hi[VALUE_WIDTH-1:0];
                        n_counter = v;
                        n_rotated = 1'b1;
                        ev_rot    = 1'b1;
                        rot_kind  = (r_dir == DIR_RIGHT) ? EV_RIGHT : EV_LEFT;
                        rot_down  = (n_phase != PH_IDLE);
                        el_ext    = HW'(el);
                        rot_held  = n_pressed ? el_ext[31:0] : 32'd0;
                    end
                    n_last_code = QC_REST;
                    n_dir       = DIR_NONE;
                end else begin
                    if ((code == QC_B_HIGH) && (r_last_code == QC_A_HIGH)) n_dir = DIR_LEFT;
                    if ((code == QC_A_HIGH) && (r_last_code == QC_B_HIGH)) n_dir = DIR_RIGHT;
                    n_last_code = code;
                end
            end
            n_elapsed = el;
        end

        cnt_ext = CW'(r_counter);
        v_ext   = CW'(n_counter);

        // slot order: long press, release or press, rotate
        ev[0] = '{kind: EV_LONG, value: cnt_ext[31:0], down: 1'b1,
                  held: held_rel, rot: rel_rot, last: 1'b0};
        if (ev_rel) begin
            ev[1] = '{kind: EV_RELEASE, value: cnt_ext[31:0], down: 1'b1,
                      held: held_rel, rot: rel_rot, last: 1'b0};
        end else begin
            ev[1] = '{kind: EV_PRESS, value: cnt_ext[31:0], down: 1'b0,
                      held: 32'd0, rot: 1'b0, last: 1'b0};
        end
        ev[2] = '{kind: rot_kind, value: v_ext[31:0], down: rot_down,
                  held: rot_held, rot: 1'b1, last: 1'b0};
        ev_ok = {ev_rot, ev_rel | ev_press, ev_long};

        // pack valid slots to the front, mark the final one
        for (int i = 0; i < MAX_EVENTS; i++) w_wr[i] = ev[2];
        idx = '0;
        for (int i = 0; i < MAX_EVENTS; i++) begin
            if (ev_ok[i]) begin
                w_wr[idx] = ev[i];
                idx       = idx + 1'b1;
            end
        end
        if (idx != '0) w_wr[idx - 1'b1].last = 1'b1;
        w_nev = idx;
    end

    assign w_pop    = o_valid & i_ready;
    assign o_ready  = (r_count - NW'(w_pop)) <= NW'(Q_DEPTH - MAX_EVENTS);
    assign w_in_acc = i_valid & o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_code <= QC_REST;
            r_dir       <= DIR_NONE;
            r_phase     <= PH_IDLE;
            r_elapsed   <= '0;
            r_counter   <= '0;
            r_pressed   <= 1'b0;
            r_rotated   <= 1'b0;
        end else if (w_in_acc) begin
            r_last_code <= n_last_code;
            r_dir       <= n_dir;
            r_phase     <= n_phase;
            r_elapsed   <= n_elapsed;
            r_counter   <= n_counter;
            r_pressed   <= n_pressed;
            r_rotated   <= n_rotated;
        end
    end

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        logic [1:0] push;
        push = w_in_acc ? w_nev : 2'd0;
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + PW'(push);
            r_rp    <= r_rp + PW'(w_pop);
            r_count <= r_count + NW'(push) - NW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            for (int j = 0; j < MAX_EVENTS; j++) begin
                if (2'(j) < w_nev) r_queue[r_wp + PW'(j)] <= w_wr[j];
            end
        end
    end

    assign o_valid       = (r_count != '0);
    assign o_event_kind  = r_queue[r_rp].kind;
    assign o_value       = r_queue[r_rp].value;
    assign o_button_down = r_queue[r_rp].down;
    assign o_held_time   = r_queue[r_rp].held;
    assign o_rotated     = r_queue[r_rp].rot;
    assign o_last        = r_queue[r_rp].last;

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(Q_DEPTH))
        else $error("result queue overfilled");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_count <= NW'(Q_DEPTH)) && (r_count >= NW'($past(w_nev))))
        else $error("events lost on accept");

    a_phase_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("illegal button phase");

    a_dir_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dir != 2'd3)
        else $error("illegal pending direction");

    a_button_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_opcode == OP_SAMPLE) && !r_button_en) |=> (r_phase == PH_IDLE))
        else $error("button phase not idle while disabled");

endmodule
